### rtl/erfb_pkg.sv
package erfb_pkg;

  // shared divider geometry: widest dividend is the squared range fall
  localparam int unsigned DIV_W = 26;
  localparam int unsigned DVS_W = 13;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // fixed arithmetic constants
  localparam logic [DVS_W-1:0] GUARD_DIVISOR = 13'd8000;
  localparam logic [DIV_W-1:0] RAW_LIMIT     = 26'd400;
  localparam logic [DIV_W-1:0] RAW_SAT       = 26'd2047;
  localparam logic [6:0]       DUTY_MAX      = 7'd100;

  // safety level codes
  localparam logic [1:0] LVL_SAFE   = 2'd0;
  localparam logic [1:0] LVL_WARN   = 2'd1;
  localparam logic [1:0] LVL_DANGER = 2'd2;

  // register reset values
  localparam logic [7:0]  RST_TICKS_PER_CM = 8'd58;
  localparam logic [8:0]  RST_SAFE_LEVEL   = 9'd100;
  localparam logic [8:0]  RST_WARN_LEVEL   = 9'd50;
  localparam logic [9:0]  RST_REVERSE_MS   = 10'd120;
  localparam logic [6:0]  RST_REVERSE_DUTY = 7'd70;
  localparam logic [6:0]  RST_CRUISE_DUTY  = 7'd40;
  localparam logic [7:0]  RST_GUARD_MIN    = 8'd22;
  localparam logic [7:0]  RST_GUARD_MAX    = 8'd45;
  localparam logic [8:0]  RST_SAMPLE_CM    = 9'd150;
  localparam logic [12:0] RST_MEAN         = 13'd2400;
  localparam logic [11:0] RST_GUARD        = 12'd480;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TICKS_PER_CM     = 3'd0,
    CFG_SAFE_LEVEL_CM    = 3'd1,
    CFG_WARN_LEVEL_CM    = 3'd2,
    CFG_BRAKE_REVERSE_MS = 3'd3,
    CFG_REVERSE_DUTY     = 3'd4,
    CFG_CRUISE_DUTY      = 3'd5,
    CFG_GUARD_MIN_CM     = 3'd6,
    CFG_GUARD_MAX_CM     = 3'd7
  } erfb_cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW_DIV,
    ST_SUM,
    ST_MEAN_DIV,
    ST_DRIVE,
    ST_SQUARE,
    ST_GUARD_DIV,
    ST_GUARD
  } erfb_state_e;

  // request into the shared divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } erfb_div_req_t;

endpackage

### rtl/erfb_div.sv
module erfb_div
  import erfb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  erfb_div_req_t    req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_sub;
  logic                 fits;

  // one restoring step a cycle, quotient bits shift into the dividend
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIV_W-1]};
    fits    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dvd_d = {dvd_q[DIV_W-2:0], fits};
        rem_d = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands need no reset
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = dvd_q;

endmodule

### rtl/echo_range_filter_brake_core.sv
// Rising echo edge: latches the capture value, no result.
// Falling echo edge: between acceptance and result come
// two passes of the 26-step shared divider plus one ring entry summed per cycle.
// Speed tick: one multiply then one divider pass.
// One item at a time; the output register holds a result while the next item is taken.
// Asynchronous active-low reset loads configuration, block state and ring to reset values.
module echo_range_filter_brake_core
  import erfb_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic               edge_high_i,
  input  logic [15:0]        capture_value_i,
  input  logic [31:0]        now_ms_i,
  input  logic               self_drive_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        raw_distance_cm_o,
  output logic [12:0]        mean_range_o,
  output logic [1:0]         safety_level_o,
  output logic               motor_update_o,
  output logic signed [7:0]  left_drive_o,
  output logic signed [7:0]  right_drive_o,
  output logic               braking_o,
  output logic [11:0]        guard_distance_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = 9 + $clog2(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  // configuration registers
  logic [7:0] tpc_q;
  logic [8:0] safe_q, warn_q;
  logic [9:0] rev_ms_q;
  logic [6:0] rev_duty_q, cru_duty_q;
  logic [7:0] gmin_q, gmax_q;

  // block state
  erfb_state_e      state_q, state_d;
  logic [15:0]      echo_q, echo_d;
  logic [8:0]       ring_q [WINDOW];
  logic [IDX_W-1:0] ring_idx_q, ring_idx_d;
  logic [12:0]      mean_q, mean_d;
  logic [12:0]      prior_q, prior_d;
  logic [11:0]      guard_q, guard_d;
  logic             brake_q, brake_d;
  logic [31:0]      began_q, began_d;

  // per-item working registers
  logic [31:0]      now_q, now_d;
  logic             auto_q, auto_d;
  logic [10:0]      raw_q, raw_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [IDX_W-1:0] sum_idx_q, sum_idx_d;
  logic [13:0]      diff_q, diff_d;

  // output register
  logic               out_valid_q;
  logic               out_load;
  logic [10:0]        o_raw_q, o_raw_d;
  logic [12:0]        o_mean_q;
  logic [1:0]         o_level_q, o_level_d;
  logic               o_upd_q, o_upd_d;
  logic signed [7:0]  o_drive_q, o_drive_d;
  logic               o_brake_q;
  logic [11:0]        o_guard_q;

  // shared divider
  erfb_div_req_t    div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  // combinational helpers
  logic             in_acc;
  logic             out_free;
  logic             ring_we;
  logic [15:0]      pulse_width;
  logic [7:0]       tpc_eff;
  logic [SUM_W-1:0] sum_nx;
  logic [12:0]      diff_mag;
  logic             diff_ge2;
  logic [14:0]      g_raw, g_lo, g_hi, g_low_clamped;
  logic [31:0]      began_eff, elapsed;
  logic [6:0]       rev_cap, cru_cap;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q      <= RST_TICKS_PER_CM;
      safe_q     <= RST_SAFE_LEVEL;
      warn_q     <= RST_WARN_LEVEL;
      rev_ms_q   <= RST_REVERSE_MS;
      rev_duty_q <= RST_REVERSE_DUTY;
      cru_duty_q <= RST_CRUISE_DUTY;
      gmin_q     <= RST_GUARD_MIN;
      gmax_q     <= RST_GUARD_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TICKS_PER_CM:     tpc_q      <= cfg_data_i[7:0];
        CFG_SAFE_LEVEL_CM:    safe_q     <= cfg_data_i[8:0];
        CFG_WARN_LEVEL_CM:    warn_q     <= cfg_data_i[8:0];
        CFG_BRAKE_REVERSE_MS: rev_ms_q   <= cfg_data_i[9:0];
        CFG_REVERSE_DUTY:     rev_duty_q <= cfg_data_i[6:0];
        CFG_CRUISE_DUTY:      cru_duty_q <= cfg_data_i[6:0];
        CFG_GUARD_MIN_CM:     gmin_q     <= cfg_data_i[7:0];
        CFG_GUARD_MAX_CM:     gmax_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // operand preparation
  always_comb begin
    pulse_width   = capture_value_i - echo_q;
    tpc_eff       = (tpc_q == '0) ? 8'd1 : tpc_q;
    sum_nx        = sum_q + SUM_W'(ring_q[sum_idx_q]);
    diff_mag      = diff_q[12:0];
    diff_ge2      = !diff_q[13] && (diff_mag >= 13'd2);
    g_raw         = diff_ge2 ? (15'(diff_mag[12:1]) + 15'(div_quo[13:0])) : '0;
    g_lo          = 15'({gmin_q, 4'b0000});
    g_hi          = 15'({gmax_q, 4'b0000});
    g_low_clamped = (g_raw < g_lo) ? g_lo : g_raw;
    began_eff     = brake_q ? began_q : now_q;
    elapsed       = now_q - began_eff;
    rev_cap       = (rev_duty_q > DUTY_MAX) ? DUTY_MAX : rev_duty_q;
    cru_cap       = (cru_duty_q > DUTY_MAX) ? DUTY_MAX : cru_duty_q;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d    = state_q;
    echo_d     = echo_q;
    ring_idx_d = ring_idx_q;
    mean_d     = mean_q;
    prior_d    = prior_q;
    guard_d    = guard_q;
    brake_d    = brake_q;
    began_d    = began_q;
    now_d      = now_q;
    auto_d     = auto_q;
    raw_d      = raw_q;
    sum_d      = sum_q;
    sum_idx_d  = sum_idx_q;
    diff_d     = diff_q;
    div_req    = '0;
    ring_we    = 1'b0;
    out_load   = 1'b0;
    o_raw_d    = '0;
    o_upd_d    = 1'b0;
    o_drive_d  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d  = now_ms_i;
          auto_d = self_drive_i;
          if (kind_i) begin
            diff_d  = $signed({1'b0, prior_q}) - $signed({1'b0, mean_q});
            state_d = ST_SQUARE;
          end else if (edge_high_i) begin
            echo_d = capture_value_i;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(pulse_width);
            div_req.divisor  = DVS_W'(tpc_eff);
            state_d          = ST_RAW_DIV;
          end
        end
      end

      // raw range, then ring push for readings in range
      ST_RAW_DIV: begin
        if (div_done) begin
          raw_d = (div_quo > RAW_SAT) ? RAW_SAT[10:0] : div_quo[10:0];
          if ((div_quo != '0) && (div_quo < RAW_LIMIT)) begin
            ring_we    = 1'b1;
            ring_idx_d = (ring_idx_q == IDX_LAST) ? '0 : ring_idx_q + 1'b1;
          end
          sum_d     = '0;
          sum_idx_d = '0;
          state_d   = ST_SUM;
        end
      end

      // one ring entry a cycle into the sum
      ST_SUM: begin
        if (sum_idx_q == IDX_LAST) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'({sum_nx, 4'b0000});
          div_req.divisor  = DVS_W'(WINDOW);
          state_d          = ST_MEAN_DIV;
        end else begin
          sum_d     = sum_nx;
          sum_idx_d = sum_idx_q + 1'b1;
        end
      end

      ST_MEAN_DIV: begin
        if (div_done) begin
          mean_d  = div_quo[12:0];
          state_d = ST_DRIVE;
        end
      end

      // brake decision and echo result
      ST_DRIVE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_raw_d  = raw_q;
          if (auto_q) begin
            o_upd_d = 1'b1;
            if (mean_q <= {1'b0, guard_q}) begin
              brake_d = 1'b1;
              began_d = began_eff;
              if (elapsed <= 32'(rev_ms_q)) begin
                o_drive_d = -$signed({1'b0, rev_cap});
              end
            end else begin
              brake_d   = 1'b0;
              o_drive_d = $signed({1'b0, cru_cap});
            end
          end
          state_d = ST_IDLE;
        end
      end

      // square of the range fall straight into the divider
      ST_SQUARE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(diff_mag) * DIV_W'(diff_mag);
        div_req.divisor  = GUARD_DIVISOR;
        state_d          = ST_GUARD_DIV;
      end

      ST_GUARD_DIV: begin
        if (div_done) begin
          state_d = ST_GUARD;
        end
      end

      // clamp the guard distance and emit the tick result
      ST_GUARD: begin
        if (out_free) begin
          out_load = 1'b1;
          guard_d  = (g_low_clamped > g_hi) ? g_hi[11:0] : g_low_clamped[11:0];
          prior_d  = mean_q;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // level of the mean that the result reports
  always_comb begin
    if (mean_q >= {safe_q, 4'b0000}) begin
      o_level_d = LVL_SAFE;
    end else if (mean_q >= {warn_q, 4'b0000}) begin
      o_level_d = LVL_WARN;
    end else begin
      o_level_d = LVL_DANGER;
    end
  end

  erfb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      echo_q      <= '0;
      ring_idx_q  <= '0;
      mean_q      <= RST_MEAN;
      prior_q     <= RST_MEAN;
      guard_q     <= RST_GUARD;
      brake_q     <= 1'b0;
      began_q     <= '0;
      sum_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      echo_q      <= echo_d;
      ring_idx_q  <= ring_idx_d;
      mean_q      <= mean_d;
      prior_q     <= prior_d;
      guard_q     <= guard_d;
      brake_q     <= brake_d;
      began_q     <= began_d;
      sum_idx_q   <= sum_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= RST_SAMPLE_CM;
      end
    end else if (ring_we) begin
      ring_q[ring_idx_q] <= div_quo[8:0];
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    auto_q <= auto_d;
    raw_q  <= raw_d;
    sum_q  <= sum_d;
    diff_q <= diff_d;
    if (out_load) begin
      o_raw_q   <= o_raw_d;
      o_mean_q  <= mean_q;
      o_level_q <= o_level_d;
      o_upd_q   <= o_upd_d;
      o_drive_q <= o_drive_d;
      o_brake_q <= brake_d;
      o_guard_q <= guard_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign raw_distance_cm_o   = o_raw_q;
  assign mean_range_o        = o_mean_q;
  assign safety_level_o      = o_level_q;
  assign motor_update_o      = o_upd_q;
  assign left_drive_o        = o_drive_q;
  assign right_drive_o       = o_drive_q;
  assign braking_o           = o_brake_q;
  assign guard_distance_o    = o_guard_q;

`ifndef ASSERT_OFF
  // ring write pointer stays inside the window
  a_ring_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_idx_q <= IDX_LAST)
    else $error("ring index beyond window");

  // a rising echo edge only latches the start time
  a_rising_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !kind_i && edge_high_i) |=> (state_q == ST_IDLE))
    else $error("rising edge started a computation");

  // mean of in-range readings never exceeds 399 cm
  a_mean_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_q <= 13'd6384)
    else $error("mean distance out of range");

  // results are only produced at the end of a computation
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !out_load)
    else $error("result loaded while idle");
`endif

endmodule

### test/echo_range_filter_brake_core_tb.sv
`timescale 1ns / 1ps

module echo_range_filter_brake_core_tb;
  import erfb_pkg::*;

  localparam int unsigned RING_DEPTH    = 5;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam int unsigned REG_TOP [8]   = '{255, 511, 511, 1023, 127, 127, 255, 255};

  typedef struct packed {
    logic        kind;
    logic        edge_high;
    logic [15:0] capture;
    logic [31:0] now_ms;
    logic        self_drive;
  } echo_item_t;

  typedef struct packed {
    logic [10:0]       raw_cm;
    logic [12:0]       filtered;
    logic [1:0]        level;
    logic              motor_update;
    logic signed [7:0] left_duty;
    logic signed [7:0] right_duty;
    logic              braking;
    logic [11:0]       guard;
  } range_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_op_e;

  typedef struct packed {
    row_op_e       op;
    echo_item_t    item;
    logic          typed;
    range_result_t want;
    erfb_cfg_idx_e reg_idx;
    logic [15:0]   reg_data;
  } stim_row_t;

  // clock, reset and block ports
  logic               clk             = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall_o;
  logic               kind_in         = 1'b0;
  logic               edge_high_in    = 1'b0;
  logic [15:0]        capture_in      = '0;
  logic [31:0]        now_ms_in       = '0;
  logic               self_drive_in   = 1'b0;
  logic               out_valid_o;
  logic               out_stall       = 1'b0;
  logic [10:0]        raw_distance_cm_o;
  logic [12:0]        mean_range_o;
  logic [1:0]         safety_level_o;
  logic               motor_update_o;
  logic signed [7:0]  left_drive_o;
  logic signed [7:0]  right_drive_o;
  logic               braking_o;
  logic [11:0]        guard_distance_o;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index       = '0;
  logic [15:0]        cfg_data        = '0;

  // predicted register file and block state
  logic [7:0]  ticks_per_cm_r;
  logic [8:0]  safe_level_r;
  logic [8:0]  warn_level_r;
  logic [9:0]  reverse_ms_r;
  logic [6:0]  reverse_duty_r;
  logic [6:0]  cruise_duty_r;
  logic [7:0]  guard_min_r;
  logic [7:0]  guard_max_r;
  logic [15:0] echo_start_q;
  logic [8:0]  ring_q [RING_DEPTH];
  int unsigned ring_pos;
  logic [12:0] mean_q;
  logic [12:0] prior_q;
  logic [11:0] guard_q;
  logic        braking_q;
  logic [31:0] brake_began_q;

  range_result_t pending_readings [$];
  stim_row_t     directed_rows [$];

  int unsigned sender_pct   = 0;
  int unsigned receiver_pct = 0;
  bit          busy         = 1'b0;
  bit          cfg_open     = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned pulses_sent  = 0;
  int unsigned ticks_sent   = 0;
  int unsigned settings     = 0;
  int unsigned readings_checked = 0;
  int unsigned braking_seen = 0;
  int unsigned drives_seen  = 0;

  echo_range_filter_brake_core #(
    .WINDOW(RING_DEPTH)
  ) DUT (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_in),
    .edge_high_i         (edge_high_in),
    .capture_value_i     (capture_in),
    .now_ms_i            (now_ms_in),
    .self_drive_i        (self_drive_in),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .raw_distance_cm_o   (raw_distance_cm_o),
    .mean_range_o        (mean_range_o),
    .safety_level_o      (safety_level_o),
    .motor_update_o      (motor_update_o),
    .left_drive_o        (left_drive_o),
    .right_drive_o       (right_drive_o),
    .braking_o           (braking_o),
    .guard_distance_o    (guard_distance_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_range_model();
    ticks_per_cm_r = RST_TICKS_PER_CM;
    safe_level_r   = RST_SAFE_LEVEL;
    warn_level_r   = RST_WARN_LEVEL;
    reverse_ms_r   = RST_REVERSE_MS;
    reverse_duty_r = RST_REVERSE_DUTY;
    cruise_duty_r  = RST_CRUISE_DUTY;
    guard_min_r    = RST_GUARD_MIN;
    guard_max_r    = RST_GUARD_MAX;
    echo_start_q   = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring_q[i] = RST_SAMPLE_CM;
    ring_pos       = 0;
    mean_q         = RST_MEAN;
    prior_q        = RST_MEAN;
    guard_q        = RST_GUARD;
    braking_q      = 1'b0;
    brake_began_q  = '0;
  endfunction

  // register write, only the field's own bits are kept
  function automatic void apply_register(input erfb_cfg_idx_e idx, input logic [15:0] data);
    case (idx)
      CFG_TICKS_PER_CM:     ticks_per_cm_r = data[7:0];
      CFG_SAFE_LEVEL_CM:    safe_level_r   = data[8:0];
      CFG_WARN_LEVEL_CM:    warn_level_r   = data[8:0];
      CFG_BRAKE_REVERSE_MS: reverse_ms_r   = data[9:0];
      CFG_REVERSE_DUTY:     reverse_duty_r = data[6:0];
      CFG_CRUISE_DUTY:      cruise_duty_r  = data[6:0];
      CFG_GUARD_MIN_CM:     guard_min_r    = data[7:0];
      CFG_GUARD_MAX_CM:     guard_max_r    = data[7:0];
      default: ;
    endcase
  endfunction

  // range, filter, guard and brake prediction for one item; 0 when no reading follows
  function automatic bit predict_range_step(input echo_item_t it, output range_result_t res);
    int          fall;
    int unsigned g;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned divisor;
    int unsigned raw;
    int unsigned total;
    int          duty;
    logic [31:0] elapsed;
    bit          upd;
    res  = '0;
    raw  = 0;
    duty = 0;
    upd  = 1'b0;
    if (!it.kind && it.edge_high) begin
      echo_start_q = it.capture;
      return 1'b0;
    end
    if (it.kind) begin
      // speed tick: guard from the fall in mean distance
      fall = int'(prior_q) - int'(mean_q);
      g    = 0;
      lo   = 32'(guard_min_r) * 16;
      hi   = 32'(guard_max_r) * 16;
      if (fall >= 2) g = fall / 2 + (fall * fall) / 8000;
      if (g < lo) g = lo;
      if (g > hi) g = hi;
      guard_q = g[11:0];
      prior_q = mean_q;
    end else begin
      // falling edge: pulse width, ring update and mean
      span    = 32'(16'(it.capture - echo_start_q));
      divisor = (ticks_per_cm_r == 0) ? 1 : 32'(ticks_per_cm_r);
      raw     = span / divisor;
      if (raw > 0 && raw < 400) begin
        ring_q[ring_pos] = raw[8:0];
        ring_pos = (ring_pos + 1) % RING_DEPTH;
      end
      total = 0;
      for (int i = 0; i < RING_DEPTH; i++) total += 32'(ring_q[i]);
      mean_q = 13'((total * 16) / RING_DEPTH);
      if (it.self_drive) begin
        upd = 1'b1;
        if (32'(mean_q) <= 32'(guard_q)) begin
          if (!braking_q) begin
            braking_q     = 1'b1;
            brake_began_q = it.now_ms;
          end
          elapsed = it.now_ms - brake_began_q;
          if (elapsed <= 32'(reverse_ms_r))
            duty = -int'((reverse_duty_r > DUTY_MAX) ? DUTY_MAX : reverse_duty_r);
        end else begin
          braking_q = 1'b0;
          duty = int'((cruise_duty_r > DUTY_MAX) ? DUTY_MAX : cruise_duty_r);
        end
      end
    end
    res.raw_cm       = (raw > 2047) ? 11'd2047 : raw[10:0];
    res.filtered     = mean_q;
    if (32'(mean_q) >= 32'(safe_level_r) * 16)      res.level = LVL_SAFE;
    else if (32'(mean_q) >= 32'(warn_level_r) * 16) res.level = LVL_WARN;
    else                                            res.level = LVL_DANGER;
    res.motor_update = upd;
    res.left_duty    = duty[7:0];
    res.right_duty   = duty[7:0];
    res.braking      = braking_q;
    res.guard        = guard_q;
    return 1'b1;
  endfunction

  function automatic range_result_t reading(input int raw, input int filt, input logic [1:0] lvl,
                                            input logic upd, input int duty, input logic brk,
                                            input int guard);
    range_result_t r;
    r.raw_cm       = raw[10:0];
    r.filtered     = filt[12:0];
    r.level        = lvl;
    r.motor_update = upd;
    r.left_duty    = duty[7:0];
    r.right_duty   = duty[7:0];
    r.braking      = brk;
    r.guard        = guard[11:0];
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic k, input logic e, input logic [15:0] cap,
                                         input logic [31:0] now, input logic am,
                                         input logic typed, input range_result_t want);
    stim_row_t row;
    row                 = '0;
    row.op              = ROW_ITEM;
    row.item.kind       = k;
    row.item.edge_high  = e;
    row.item.capture    = cap;
    row.item.now_ms     = now;
    row.item.self_drive = am;
    row.typed           = typed;
    row.want            = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input erfb_cfg_idx_e idx, input logic [15:0] data);
    stim_row_t row;
    row          = '0;
    row.op       = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  // present one item, hold it until taken, then queue its reading
  task automatic send_item(input echo_item_t it, input logic typed, input range_result_t want);
    range_result_t model;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    while ($urandom_range(0, 99) < sender_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind_in       <= it.kind;
    edge_high_in  <= it.edge_high;
    capture_in    <= it.capture;
    now_ms_in     <= it.now_ms;
    self_drive_in <= it.self_drive;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    busy = 1'b1;
    items_sent++;
    if (it.kind) ticks_sent++;
    else if (!it.edge_high) pulses_sent++;
    if (predict_range_step(it, model)) pending_readings.push_back(typed ? want : model);
  endtask

  // drain outstanding readings and let the sequencer go idle
  task automatic settle();
    if (busy) begin
      in_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      busy = 1'b0;
    end
  endtask

  task automatic write_reg(input erfb_cfg_idx_e idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_open = 1'b1;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: check each taken item, then pick the next stall
  always @(posedge clk) begin
    range_result_t got;
    range_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      got.raw_cm       = raw_distance_cm_o;
      got.filtered     = mean_range_o;
      got.level        = safety_level_o;
      got.motor_update = motor_update_o;
      got.left_duty    = left_drive_o;
      got.right_duty   = right_drive_o;
      got.braking      = braking_o;
      got.guard        = guard_distance_o;
      if (pending_readings.size() == 0) begin
        $error("reading raw=%0d mean=%0d with nothing expected",
               got.raw_cm, got.filtered);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (want.braking) braking_seen++;
        if (want.motor_update) drives_seen++;
        compare_field("raw_distance_cm", int'(want.raw_cm), int'(got.raw_cm));
        compare_field("mean_range", int'(want.filtered), int'(got.filtered));
        compare_field("safety_level", int'(want.level), int'(got.level));
        compare_field("motor_update", int'(want.motor_update), int'(got.motor_update));
        compare_field("left_drive", int'(want.left_duty), int'(got.left_duty));
        compare_field("right_drive", int'(want.right_duty), int'(got.right_duty));
        compare_field("braking", int'(want.braking), int'(got.braking));
        compare_field("guard_distance", int'(want.guard), int'(got.guard));
      end
    end
    out_stall <= ($urandom_range(0, 99) < receiver_pct);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    echo_item_t  it;
    int unsigned phase;
    int unsigned phase_items;
    int unsigned pick;
    int unsigned tpc_eff;
    int unsigned span;
    int unsigned range_cm;
    int unsigned val;
    int          target_cm;
    logic [31:0] clock_ms;
    logic [15:0] rise_cap;
    logic [15:0] data;

    reset_range_model();

    // directed rows, default settings first
    directed_rows.push_back(item_row(1'b1, 1'b1, 16'hBEEF, 32'd0, 1'b1, 1'b1,
                            reading(0, 2400, LVL_SAFE, 1'b0, 0, 1'b0, 352)));
    directed_rows.push_back(item_row(1'b0, 1'b1, 16'h0000, 32'd0, 1'b1, 1'b0, '0));
    // zero width pulse is out of range
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h0000, 32'd0, 1'b1, 1'b1,
                            reading(0, 2400, LVL_SAFE, 1'b1, 40, 1'b0, 352)));
    directed_rows.push_back(item_row(1'b0, 1'b1, 16'hFFFF, 32'd5, 1'b0, 1'b0, '0));
    // widest pulse, manual mode
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'hFFFE, 32'd5, 1'b0, 1'b1,
                            reading(1129, 2400, LVL_SAFE, 1'b0, 0, 1'b0, 352)));
    directed_rows.push_back(item_row(1'b0, 1'b1, 16'd1000, 32'd8, 1'b1, 1'b0, '0));
    // top in-range reading, 399 cm
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'd24142, 32'd10, 1'b1, 1'b0, '0));
    // 1 cm readings across the timer wrap drive the mean into danger and braking
    directed_rows.push_back(item_row(1'b0, 1'b1, 16'hFFF0, 32'd15, 1'b1, 1'b0, '0));
    for (int i = 1; i <= 4; i++)
      directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'(20 * i), 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'hFFFF_FFF0, 1'b1, 1'b0, '0));
    // reverse window edge across the millisecond wrap
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'h0000_0068, 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'h0000_0069, 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'h0000_0100, 1'b0, 1'b0, '0));
    // guard clamped to its maximum after a steep fall
    directed_rows.push_back(item_row(1'b1, 1'b0, 16'h0000, 32'h0000_0200, 1'b1, 1'b1,
                            reading(0, 16, LVL_DANGER, 1'b0, 0, 1'b1, 720)));
    // zero ticks per cm acts as one, raw saturates
    directed_rows.push_back(reg_row(CFG_TICKS_PER_CM, 16'hA500));
    directed_rows.push_back(item_row(1'b0, 1'b1, 16'h0000, 32'h0000_0300, 1'b0, 1'b0, '0));
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'hFFFF, 32'h0000_0310, 1'b0, 1'b1,
                            reading(2047, 16, LVL_DANGER, 1'b0, 0, 1'b1, 720)));
    // duties above 100 and crossed guard clamps
    directed_rows.push_back(reg_row(CFG_REVERSE_DUTY, 16'hFF7F));
    directed_rows.push_back(reg_row(CFG_CRUISE_DUTY, 16'h007F));
    directed_rows.push_back(reg_row(CFG_GUARD_MIN_CM, 16'h12FF));
    directed_rows.push_back(reg_row(CFG_GUARD_MAX_CM, 16'hFF00));
    directed_rows.push_back(item_row(1'b1, 1'b1, 16'h5555, 32'h0000_0400, 1'b1, 1'b1,
                            reading(0, 16, LVL_DANGER, 1'b0, 0, 1'b1, 0)));
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'h0000_0410, 1'b1, 1'b0, '0));
    directed_rows.push_back(reg_row(CFG_GUARD_MAX_CM, 16'h00FF));
    directed_rows.push_back(item_row(1'b1, 1'b0, 16'hAAAA, 32'h0000_0800, 1'b1, 1'b0, '0));
    directed_rows.push_back(item_row(1'b0, 1'b0, 16'h002A, 32'h0000_1000, 1'b1, 1'b0, '0));

    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    sender_pct   = 23;
    receiver_pct = 23;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_REG) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        settings++;
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each under its own settings and idling pattern
    clock_ms  = $urandom;
    target_cm = $urandom_range(10, 150);
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_pct = 0;  receiver_pct = 0;  end
        1: begin sender_pct = 69; receiver_pct = 0;  end
        2: begin sender_pct = 0;  receiver_pct = 69; end
        default: begin sender_pct = 23; receiver_pct = 23; end
      endcase
      settle();
      for (int r = 0; r < 8; r++) begin
        case (phase % 3)
          1: val = (r == CFG_TICKS_PER_CM && phase != 1) ? 1 : 0;
          2: val = REG_TOP[r];
          default: val = $urandom_range(0, REG_TOP[r]);
        endcase
        // bits above the field are random and must be dropped
        data = (16'($urandom) & ~16'(REG_TOP[r])) | 16'(val);
        write_reg(erfb_cfg_idx_e'(r), data);
      end
      settings++;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(5, 60);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // speed tick, edge and capture ignored
          it.kind       = 1'b1;
          it.edge_high  = $urandom_range(0, 1);
          it.capture    = 16'($urandom);
          it.now_ms     = clock_ms;
          it.self_drive = $urandom_range(0, 1);
          send_item(it, 1'b0, '0);
          phase_items++;
        end else if (pick < 14) begin
          // noise: any item at all
          it.kind       = $urandom_range(0, 1);
          it.edge_high  = $urandom_range(0, 1);
          it.capture    = 16'($urandom);
          it.now_ms     = $urandom;
          it.self_drive = $urandom_range(0, 1);
          send_item(it, 1'b0, '0);
          phase_items++;
        end else begin
          // echo pulse: rising then falling edge around the drifting range
          tpc_eff = (ticks_per_cm_r == 0) ? 1 : 32'(ticks_per_cm_r);
          pick = $urandom_range(0, 99);
          if (pick < 8)       range_cm = 0;
          else if (pick < 15) range_cm = $urandom_range(400, 1200);
          else begin
            range_cm = target_cm + $urandom_range(0, 6);
            range_cm = (range_cm < 3) ? 0 : range_cm - 3;
          end
          span     = tpc_eff * range_cm + $urandom_range(0, tpc_eff - 1);
          rise_cap = 16'($urandom);
          it.kind       = 1'b0;
          it.edge_high  = 1'b1;
          it.capture    = rise_cap;
          it.now_ms     = clock_ms;
          it.self_drive = ($urandom_range(0, 9) != 0);
          send_item(it, 1'b0, '0);
          clock_ms    += $urandom_range(0, 3);
          it.edge_high = 1'b0;
          it.capture   = rise_cap + span[15:0];
          it.now_ms    = clock_ms;
          send_item(it, 1'b0, '0);
          phase_items += 2;
          target_cm -= $urandom_range(0, 8);
          if (target_cm < 2) target_cm = ($urandom_range(0, 4) == 0) ? 399 :
                                         $urandom_range(10, 150);
        end
      end
    end

    // drain and finish
    if (cfg_open) cfg_valid <= 1'b0;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d falling edges, %0d speed ticks) under %0d register settings",
             items_sent, pulses_sent, ticks_sent, settings);
    $display("Checked %0d readings: %0d with drive applied, %0d while braking",
             readings_checked, drives_seen, braking_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/erfb_pkg.sv
rtl/erfb_div.sv
rtl/echo_range_filter_brake_core.sv
test/echo_range_filter_brake_core_tb.sv
